[hdl/srd_pkg.sv]
// Package for the radial deadzone block: constants, pipeline word types.
// Used by every file of the block; depends on nothing.
package srd_pkg;

    localparam int SAMPLE_BITS  = 16;
    localparam int SAMPLE_SHIFT = 16 - SAMPLE_BITS;
    localparam longint FULL_SCALE = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;
    // Length floor of 0.0001 in raw units with 16 fraction bits, rounded.
    localparam longint LEN_FLOOR = (FULL_SCALE * 64'd65536 + 64'd5000) / 64'd10000;

    localparam int SQRT_STEPS   = 32;
    localparam int SCDIV_STEPS  = 30;
    localparam int OUTDIV_STEPS = 17;
    localparam int LATENCY = 10 + 2 * SQRT_STEPS + SCDIV_STEPS + OUTDIV_STEPS;

    localparam logic [1:0] CFG_INNER = 2'd0;
    localparam logic [1:0] CFG_OUTER = 2'd1;

    typedef enum logic [1:0] {
        SC_ZERO = 2'd0,
        SC_FULL = 2'd1,
        SC_DIV  = 2'd2
    } sc_mode_t;

    typedef struct packed {
        logic [34:0] rem;
        logic [31:0] root;
        logic [63:0] rad;
    } sqrt_t;

    typedef struct packed {
        logic [31:0] rem;
        logic [31:0] den;
        logic [31:0] lo;
        logic [31:0] quo;
    } div_t;

    typedef struct packed {
        logic               neg_x;
        logic               neg_y;
        logic               curve;
        logic               zero;
        logic [15:0]        ax;
        logic [15:0]        ay;
        sc_mode_t           mode;
        logic [31:0]        rf;
        logic signed [15:0] cx;
        logic signed [15:0] cy;
        logic [15:0]        mx;
        logic [15:0]        my;
    } item_t;

endpackage

[hdl/srd_sqrt_cell.sv]
// One digit cell of the pipelined square root: two radicand bits per cycle.
// Depends on srd_pkg.
module srd_sqrt_cell (
    input  logic          clk,
    input  srd_pkg::sqrt_t d_in,
    output srd_pkg::sqrt_t d_out
);
    import srd_pkg::*;

    sqrt_t       cell_reg;
    sqrt_t       cell_next;
    logic [34:0] acc;
    logic [34:0] trial;

    always_comb
    begin
        acc = {d_in.rem[32:0], d_in.rad[63:62]};
        trial = {1'b0, d_in.root, 2'b01};
        cell_next.rad = {d_in.rad[61:0], 2'b00};
        if (acc >= trial)
        begin
            cell_next.rem  = acc - trial;
            cell_next.root = {d_in.root[30:0], 1'b1};
        end
        else
        begin
            cell_next.rem  = acc;
            cell_next.root = {d_in.root[30:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        cell_reg <= cell_next;
    end

    assign d_out = cell_reg;

endmodule

[hdl/srd_div_cell.sv]
// One restoring division cell: brings down one numerator bit per cycle.
// Depends on srd_pkg.
module srd_div_cell (
    input  logic          clk,
    input  srd_pkg::div_t d_in,
    output srd_pkg::div_t d_out
);
    import srd_pkg::*;

    div_t        cell_reg;
    div_t        cell_next;
    logic [32:0] acc;
    logic [32:0] diff;

    always_comb
    begin
        acc = {d_in.rem, d_in.lo[31]};
        diff = acc - {1'b0, d_in.den};
        cell_next.den = d_in.den;
        cell_next.lo  = {d_in.lo[30:0], 1'b0};
        if (acc >= {1'b0, d_in.den})
        begin
            cell_next.rem = diff[31:0];
            cell_next.quo = {d_in.quo[30:0], 1'b1};
        end
        else
        begin
            cell_next.rem = acc[31:0];
            cell_next.quo = {d_in.quo[30:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        cell_reg <= cell_next;
    end

    assign d_out = cell_reg;

endmodule

[hdl/stick_radial_deadzone.sv]
// Top level of the radial deadzone block: a chain of square root and divider cells.
// Depends on srd_pkg, srd_sqrt_cell and srd_div_cell.
//
//  channel | handshake             | words
//  --------+-----------------------+-----------------------------------------
//  input   | start, busy           | raw_x, raw_y, curve
//  result  | done (one-cycle)      | cond_x, cond_y, shaped_x, shaped_y
//  config  | cfg_valid, cfg_ready  | cfg_index, cfg_data
//
// A word is taken in every cycle; busy is never raised.
// Each result passes through two 32-cell square root chains, a 30-cell and a 17-cell
// divider chain, and 10 more registered stages.
// Reset clears the configuration and the valid pipe only.
// Results cannot be stalled; the pipeline always advances.
module stick_radial_deadzone (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] raw_x,
    input  logic signed [15:0] raw_y,
    input  logic               curve,
    output logic               done,
    output logic signed [15:0] cond_x,
    output logic signed [15:0] cond_y,
    output logic signed [15:0] shaped_x,
    output logic signed [15:0] shaped_y,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data
);
    import srd_pkg::*;

    localparam logic [31:0] LEN_FLOOR_W = 32'(LEN_FLOOR);
    localparam logic [14:0] FS_W        = 15'(FULL_SCALE);
    localparam logic [30:0] ONE_Q30     = 31'h4000_0000;
    localparam logic [46:0] HALF_Q30    = 47'h2000_0000;

    function automatic logic signed [15:0] sat_q15(input logic neg, input logic [17:0] mag);
        logic [17:0] negm;
        begin
            negm = 18'd0 - mag;
            if (neg)
                sat_q15 = (mag > 18'd32768) ? 16'sh8000 : negm[15:0];
            else
                sat_q15 = (mag > 18'd32767) ? 16'sh7fff : mag[15:0];
        end
    endfunction

    // Configuration.
    logic [15:0] inner_reg, inner_next;
    logic [15:0] outer_reg, outer_next;
    logic [31:0] in_lim_reg, out_lim_reg, den_reg;
    logic        overlap_reg;
    logic [16:0] sum_dz;
    logic [17:0] span;

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    always_comb
    begin
        inner_next = inner_reg;
        outer_next = outer_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_INNER: inner_next = cfg_data;
                CFG_OUTER: outer_next = cfg_data;
                default:   ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inner_reg <= '0;
            outer_reg <= '0;
        end
        else
        begin
            inner_reg <= inner_next;
            outer_reg <= outer_next;
        end
    end

    assign sum_dz = {1'b0, inner_reg} + {1'b0, outer_reg};
    assign span   = 18'h10000 - {1'b0, sum_dz};

    // Limits follow the registers in the next cycle; only stages far downstream read them.
    always_ff @(posedge clk)
    begin
        in_lim_reg  <= {16'd0, inner_reg} * {17'd0, FS_W};
        out_lim_reg <= {15'd0, 17'h10000 - {1'b0, outer_reg}} * {17'd0, FS_W};
        den_reg     <= {15'd0, span[16:0]} * {17'd0, FS_W};
        overlap_reg <= sum_dz[16];
    end

    // Valid pipe.
    logic [LATENCY-1:0] vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[LATENCY-2:0], start & ~busy};
    end

    assign done = vld_reg[LATENCY-1];

    // Stage 0: sample capture and magnitudes.
    item_t              it0_reg, it0_next;
    logic signed [15:0] xs, ys, xsh, ysh;

    always_comb
    begin
        xsh = raw_x <<< SAMPLE_SHIFT;
        ysh = raw_y <<< SAMPLE_SHIFT;
        xs  = xsh >>> SAMPLE_SHIFT;
        ys  = ysh >>> SAMPLE_SHIFT;
        it0_next       = '0;
        it0_next.neg_x = xs[15];
        it0_next.neg_y = ys[15];
        it0_next.curve = curve;
        it0_next.zero  = (xs == 16'sd0) && (ys == 16'sd0);
        it0_next.ax    = xs[15] ? 16'(-xs) : xs;
        it0_next.ay    = ys[15] ? 16'(-ys) : ys;
    end

    always_ff @(posedge clk)
    begin
        it0_reg <= it0_next;
    end

    // Stage 1: squared length.
    item_t       it1_reg;
    logic [31:0] q_reg;

    always_ff @(posedge clk)
    begin
        it1_reg <= it0_reg;
        q_reg   <= (it0_reg.ax * it0_reg.ax) + (it0_reg.ay * it0_reg.ay);
    end

    // Square root chain on the length, 16 fraction bits.
    sqrt_t sqA [0:SQRT_STEPS];
    item_t itA [0:SQRT_STEPS];

    assign sqA[0] = '{rem: '0, root: '0, rad: {q_reg, 32'd0}};
    assign itA[0] = it1_reg;

    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_sqa
        srd_sqrt_cell u_cell (.clk(clk), .d_in(sqA[k]), .d_out(sqA[k+1]));
        always_ff @(posedge clk)
        begin
            itA[k+1] <= itA[k];
        end
    end

    // Stage 2: deadzone decision and length floor.
    item_t       it2_reg, it2_next;
    logic [31:0] a2_reg;
    logic [31:0] r_len;
    logic        exact;

    always_comb
    begin
        r_len = sqA[SQRT_STEPS].root;
        exact = (sqA[SQRT_STEPS].rem == '0);
        it2_next    = itA[SQRT_STEPS];
        it2_next.rf = (r_len > LEN_FLOOR_W) ? r_len : LEN_FLOOR_W;
        if (r_len < in_lim_reg)
            it2_next.mode = SC_ZERO;
        else if (overlap_reg)
            it2_next.mode = SC_FULL;
        else if ((r_len < out_lim_reg) || ((r_len == out_lim_reg) && exact))
            it2_next.mode = SC_DIV;
        else
            it2_next.mode = SC_FULL;
    end

    always_ff @(posedge clk)
    begin
        it2_reg <= it2_next;
        a2_reg  <= r_len - in_lim_reg;
    end

    // Stage 3: top quotient bit of the rescale.
    item_t it3_reg;
    div_t  dv3_reg, dv3_next;
    logic  top_bit;

    always_comb
    begin
        top_bit      = (a2_reg >= den_reg);
        dv3_next.rem = top_bit ? (a2_reg - den_reg) : a2_reg;
        dv3_next.den = den_reg;
        dv3_next.lo  = '0;
        dv3_next.quo = {31'd0, top_bit};
    end

    always_ff @(posedge clk)
    begin
        it3_reg <= it2_reg;
        dv3_reg <= dv3_next;
    end

    // Rescale divider chain, 30 fraction bits.
    div_t  dvB [0:SCDIV_STEPS];
    item_t itB [0:SCDIV_STEPS];

    assign dvB[0] = dv3_reg;
    assign itB[0] = it3_reg;

    for (genvar k = 0; k < SCDIV_STEPS; k++)
    begin : g_dvb
        srd_div_cell u_cell (.clk(clk), .d_in(dvB[k]), .d_out(dvB[k+1]));
        always_ff @(posedge clk)
        begin
            itB[k+1] <= itB[k];
        end
    end

    // Stage 4: scale times component.
    item_t       it4_reg;
    logic [46:0] px4_reg, py4_reg;
    logic [30:0] sc;

    always_comb
    begin
        case (itB[SCDIV_STEPS].mode)
            SC_DIV:  sc = dvB[SCDIV_STEPS].quo[30:0];
            SC_FULL: sc = ONE_Q30;
            default: sc = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        it4_reg <= itB[SCDIV_STEPS];
        px4_reg <= itB[SCDIV_STEPS].ax * sc;
        py4_reg <= itB[SCDIV_STEPS].ay * sc;
    end

    // Stage 5: rounding offset and divider set-up.
    item_t       it5_reg;
    div_t        dvx5_reg, dvy5_reg;
    logic [47:0] nx, ny;

    always_comb
    begin
        nx = {px4_reg, 1'b0} + {17'd0, it4_reg.rf[31:1]};
        ny = {py4_reg, 1'b0} + {17'd0, it4_reg.rf[31:1]};
    end

    always_ff @(posedge clk)
    begin
        it5_reg  <= it4_reg;
        dvx5_reg <= '{rem: {1'b0, nx[47:17]}, den: it4_reg.rf, lo: {nx[16:0], 15'd0}, quo: '0};
        dvy5_reg <= '{rem: {1'b0, ny[47:17]}, den: it4_reg.rf, lo: {ny[16:0], 15'd0}, quo: '0};
    end

    // Direction divider chains, one lane per axis.
    div_t  dvX [0:OUTDIV_STEPS];
    div_t  dvY [0:OUTDIV_STEPS];
    item_t itC [0:OUTDIV_STEPS];

    assign dvX[0] = dvx5_reg;
    assign dvY[0] = dvy5_reg;
    assign itC[0] = it5_reg;

    for (genvar k = 0; k < OUTDIV_STEPS; k++)
    begin : g_dvc
        srd_div_cell u_cx (.clk(clk), .d_in(dvX[k]), .d_out(dvX[k+1]));
        srd_div_cell u_cy (.clk(clk), .d_in(dvY[k]), .d_out(dvY[k+1]));
        always_ff @(posedge clk)
        begin
            itC[k+1] <= itC[k];
        end
    end

    // Stage 6: conditioned outputs, saturated.
    item_t              it6_reg, it6_next;
    logic signed [15:0] cxs, cys;

    always_comb
    begin
        it6_next = itC[OUTDIV_STEPS];
        cxs = sat_q15(it6_next.neg_x, {1'b0, dvX[OUTDIV_STEPS].quo[16:0]});
        cys = sat_q15(it6_next.neg_y, {1'b0, dvY[OUTDIV_STEPS].quo[16:0]});
        if (it6_next.zero)
        begin
            cxs = '0;
            cys = '0;
        end
        it6_next.cx = cxs;
        it6_next.cy = cys;
        it6_next.mx = cxs[15] ? 16'(-cxs) : cxs;
        it6_next.my = cys[15] ? 16'(-cys) : cys;
    end

    always_ff @(posedge clk)
    begin
        it6_reg <= it6_next;
    end

    // Stage 7: squared conditioned length.
    item_t       it7_reg;
    logic [31:0] s2_reg;

    always_ff @(posedge clk)
    begin
        it7_reg <= it6_reg;
        s2_reg  <= (it6_reg.mx * it6_reg.mx) + (it6_reg.my * it6_reg.my);
    end

    // Square root chain on the conditioned length, 15 fraction bits.
    sqrt_t sqD [0:SQRT_STEPS];
    item_t itD [0:SQRT_STEPS];

    assign sqD[0] = '{rem: '0, root: '0, rad: {2'b00, s2_reg, 30'd0}};
    assign itD[0] = it7_reg;

    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_sqd
        srd_sqrt_cell u_cell (.clk(clk), .d_in(sqD[k]), .d_out(sqD[k+1]));
        always_ff @(posedge clk)
        begin
            itD[k+1] <= itD[k];
        end
    end

    // Stage 8: component times conditioned length.
    item_t       it8_reg;
    logic [46:0] qx8_reg, qy8_reg;

    always_ff @(posedge clk)
    begin
        it8_reg <= itD[SQRT_STEPS];
        qx8_reg <= itD[SQRT_STEPS].mx * sqD[SQRT_STEPS].root[30:0];
        qy8_reg <= itD[SQRT_STEPS].my * sqD[SQRT_STEPS].root[30:0];
    end

    // Stage 9: curve select and result registers.
    logic signed [15:0] cond_x_reg, cond_y_reg, shaped_x_reg, shaped_y_reg;
    logic [46:0]        rx, ry;

    always_comb
    begin
        rx = (qx8_reg + HALF_Q30) >> 30;
        ry = (qy8_reg + HALF_Q30) >> 30;
    end

    always_ff @(posedge clk)
    begin
        cond_x_reg   <= it8_reg.cx;
        cond_y_reg   <= it8_reg.cy;
        shaped_x_reg <= it8_reg.curve ? sat_q15(it8_reg.cx[15], rx[17:0]) : it8_reg.cx;
        shaped_y_reg <= it8_reg.curve ? sat_q15(it8_reg.cy[15], ry[17:0]) : it8_reg.cy;
    end

    assign cond_x   = cond_x_reg;
    assign cond_y   = cond_y_reg;
    assign shaped_x = shaped_x_reg;
    assign shaped_y = shaped_y_reg;

endmodule

[hdl/srd_check.sv]
// Port-level checks for the radial deadzone block, bound to its top level.
// Depends on srd_pkg and stick_radial_deadzone.
module srd_check (
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic signed [15:0] raw_x,
    input logic signed [15:0] raw_y,
    input logic               curve,
    input logic               done,
    input logic signed [15:0] cond_x,
    input logic signed [15:0] cond_y,
    input logic signed [15:0] shaped_x,
    input logic signed [15:0] shaped_y,
    input logic               cfg_valid,
    input logic               cfg_ready,
    input logic [1:0]         cfg_index,
    input logic [15:0]        cfg_data
);
    import srd_pkg::*;

    // Every accepted word yields a result after the fixed latency.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("accepted word produced no result");

    // No result without an accepted word.
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result without a matching input word");

    // A centered stick gives zero everywhere.
    a_zero_sample: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && raw_x == 16'sd0 && raw_y == 16'sd0) |-> ##LATENCY
        (cond_x == 16'sd0 && cond_y == 16'sd0 && shaped_x == 16'sd0 && shaped_y == 16'sd0))
        else $error("zero sample gave a nonzero result");

    // The linear curve passes the conditioned word through.
    a_linear_curve: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !curve) |-> ##LATENCY
        (shaped_x == cond_x && shaped_y == cond_y))
        else $error("linear curve changed the conditioned word");

endmodule

bind stick_radial_deadzone srd_check u_srd_check (.*);
